>>> sv/nkv_pkg.sv
// ----------------------------------------------------------------------------
// nkv_pkg
// Shared types and constants for the numeric key/value line parser.
// ----------------------------------------------------------------------------
package nkv_pkg;

    // Width of the held inner-space counter.
    localparam int SPACE_COUNT_BITS = 8;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int PHASE_W = 3;

    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;

    typedef enum logic [PHASE_W-1:0] {
        PH_LINE      = 3'd0,
        PH_KEY_ZERO  = 3'd1,
        PH_KEY       = 3'd2,
        PH_AFTER_KEY = 3'd3,
        PH_LEAD      = 3'd4,
        PH_VALUE     = 3'd5,
        PH_ERROR     = 3'd6
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_DIGIT     = 3'd0,
        K_KEY_DONE  = 3'd1,
        K_VALUE     = 3'd2,
        K_ENTRY_END = 3'd3,
        K_ACCEPT    = 3'd4,
        K_ERROR     = 3'd5
    } t_kind;

endpackage

>>> sv/numeric_key_value_line_parser.sv
// ----------------------------------------------------------------------------
// numeric_key_value_line_parser
// Checks "key: value" text lines one byte per transfer and emits tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one text byte or an end marker.
//   Output channel (o_valid / i_ready) carries one token per transfer; an
//   input item gives zero, one or two tokens, and o_last marks its final one.
//   An input transfer lands in an input register; the parse step then runs
//   on it and loads the result register, from which the token leaves. One
//   item is taken per cycle while the output drains; the end marker that
//   closes an open entry gives two tokens and holds the parse step until
//   its second token is loaded. Items with no token still pass through the
//   parse step.
//   A synchronous active-low reset empties both registers and returns the
//   parser to line start with no held spaces.
//   When the receiver stalls, the result register holds its token, the
//   input register fills, and o_ready drops until the stall clears.
// ----------------------------------------------------------------------------
module numeric_key_value_line_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [nkv_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                          i_end_marker,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [nkv_pkg::KIND_W-1:0]    o_token_kind,
    output logic [nkv_pkg::BYTE_W-1:0]    o_char_out,
    output logic [nkv_pkg::BYTE_W-1:0]    o_spaces_before,
    output logic                          o_last
);
    import nkv_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_end;

    // Parser state
    t_phase                      r_phase, n_phase;
    logic [SPACE_COUNT_BITS-1:0] r_pending, n_pending;

    // Result register and the held second token of an end marker
    logic              r_out_valid;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_char;
    logic [BYTE_W-1:0] r_spaces;
    logic              r_last;
    logic              r_sec_valid;

    // Parse step results
    logic [1:0]        res_cnt;
    t_kind             res_kind;
    logic [BYTE_W-1:0] res_char;
    logic [BYTE_W-1:0] res_spaces;
    logic              res_last;

    logic is_digit, is_print, at_limit;
    logic out_free, step, load_sec;

    assign is_digit = (r_byte >= CH_ZERO) && (r_byte <= CH_NINE);
    assign is_print = (r_byte >= PRINT_LO) && (r_byte <= PRINT_HI);
    assign at_limit = &r_pending;

    always_comb begin
        res_cnt    = 2'd0;
        res_kind   = K_ERROR;
        res_char   = '0;
        res_spaces = '0;
        res_last   = 1'b1;
        n_phase    = r_phase;
        n_pending  = r_pending;
        if (r_end) begin
            n_phase   = PH_LINE;
            n_pending = '0;
            res_cnt   = 2'd1;
            unique case (r_phase)
                PH_LINE: res_kind = K_ACCEPT;
                PH_LEAD, PH_VALUE: begin
                    res_kind = K_ENTRY_END;
                    res_last = 1'b0;
                    res_cnt  = 2'd2;
                end
                default: res_kind = K_ERROR;
            endcase
        end else begin
            unique case (r_phase)
                PH_LINE: begin
                    if (r_byte == CH_NEWLINE) begin
                        res_cnt = 2'd0;
                    end else if (!is_digit) begin
                        n_phase = PH_ERROR;
                        res_cnt = 2'd1;
                    end else begin
                        n_phase  = (r_byte == CH_ZERO) ? PH_KEY_ZERO : PH_KEY;
                        res_cnt  = 2'd1;
                        res_kind = K_DIGIT;
                        res_char = r_byte;
                    end
                end
                PH_KEY_ZERO, PH_KEY: begin
                    res_cnt = 2'd1;
                    if (is_digit) begin
                        if (r_phase == PH_KEY_ZERO) begin
                            n_phase = PH_ERROR;
                        end else begin
                            res_kind = K_DIGIT;
                            res_char = r_byte;
                        end
                    end else if (r_byte == CH_SPACE || r_byte == CH_COLON) begin
                        n_phase  = (r_byte == CH_COLON) ? PH_LEAD : PH_AFTER_KEY;
                        res_kind = K_KEY_DONE;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_AFTER_KEY: begin
                    if (r_byte == CH_COLON) begin
                        n_phase = PH_LEAD;
                    end else if (r_byte != CH_SPACE) begin
                        n_phase = PH_ERROR;
                        res_cnt = 2'd1;
                    end
                end
                PH_LEAD, PH_VALUE: begin
                    if (r_byte == CH_NEWLINE) begin
                        n_phase   = PH_LINE;
                        n_pending = '0;
                        res_cnt   = 2'd1;
                        res_kind  = K_ENTRY_END;
                    end else if (!is_print) begin
                        n_phase   = PH_ERROR;
                        n_pending = '0;
                        res_cnt   = 2'd1;
                    end else if (r_byte == CH_SPACE) begin
                        // Spaces before the first value byte are dropped.
                        if (r_phase == PH_VALUE) begin
                            if (at_limit) begin
                                n_phase   = PH_ERROR;
                                n_pending = '0;
                                res_cnt   = 2'd1;
                            end else begin
                                n_pending = r_pending + 1'b1;
                            end
                        end
                    end else begin
                        res_cnt    = 2'd1;
                        res_kind   = K_VALUE;
                        res_char   = r_byte;
                        res_spaces = BYTE_W'(r_pending);
                        n_pending  = '0;
                        n_phase    = PH_VALUE;
                    end
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;
    // The held second token goes out before the next item is parsed.
    assign load_sec = r_sec_valid && out_free;
    assign step     = r_in_valid && !r_sec_valid && (out_free || res_cnt == 2'd0);
    assign o_ready  = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_text_byte;
            r_end  <= i_end_marker;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LINE;
            r_pending <= '0;
        end else if (step) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec_valid <= 1'b0;
        end else begin
            if (load_sec) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= 1'b0;
            end else if (step && res_cnt != 2'd0) begin
                r_out_valid <= 1'b1;
                r_sec_valid <= (res_cnt == 2'd2);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_sec) begin
            r_kind   <= K_ACCEPT;
            r_char   <= '0;
            r_spaces <= '0;
            r_last   <= 1'b1;
        end else if (step && res_cnt != 2'd0) begin
            r_kind   <= res_kind;
            r_char   <= res_char;
            r_spaces <= res_spaces;
            r_last   <= res_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_token_kind    = r_kind;
    assign o_char_out      = r_char;
    assign o_spaces_before = r_spaces;
    assign o_last          = r_last;

endmodule
